FILE: rtl/temp_filter_hysteresis_alarm_assert.svh
// assertion macros used by the rtl
`ifndef TEMP_FILTER_HYSTERESIS_ALARM_ASSERT_SVH
`define TEMP_FILTER_HYSTERESIS_ALARM_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define TFHA_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tfha assertion failed");

// next-cycle implication, disabled while reset is held
`define TFHA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tfha assertion failed");

`endif

FILE: rtl/tfha_pkg.sv
package tfha_pkg;

  typedef enum logic [2:0] {
    ALARM_UNKNOWN   = 3'd0,
    ALARM_NORMAL    = 3'd1,
    ALARM_WARNING   = 3'd2,
    ALARM_CRIT_LOW  = 3'd3,
    ALARM_CRIT_HIGH = 3'd4
  } alarm_t;

  typedef enum logic [2:0] {
    CFG_SENSOR_REVISION   = 3'd0,
    CFG_WARNING_THRESHOLD = 3'd1,
    CFG_CRIT_HIGH_THRESH  = 3'd2,
    CFG_CRIT_LOW_THRESH   = 3'd3,
    CFG_HYSTERESIS_MARGIN = 3'd4
  } cfg_index_t;

  localparam logic [1:0] REV_A_DEGREES      = 2'd0;
  localparam logic [1:0] REV_B_DECI_DEGREES = 2'd1;

  localparam logic [1:0]         RESET_SENSOR_REVISION = 2'd0;
  localparam logic signed [15:0] RESET_WARNING_THRESH  = 16'sd850;
  localparam logic signed [15:0] RESET_CRIT_HIGH_THRESH = 16'sd1050;
  localparam logic signed [15:0] RESET_CRIT_LOW_THRESH = 16'sd50;
  localparam logic [9:0]         RESET_HYST_MARGIN     = 10'd10;
  localparam logic signed [15:0] RESET_FILTER_VALUE    = 16'sd200;
  localparam int                 FILTER_SHIFT          = 3;

  typedef struct packed {
    logic               op;
    logic signed [15:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] filtered_temp;
    alarm_t             alarm_state;
    logic               normal_led;
    logic               warning_led;
    logic               led_red;
    logic               state_changed;
  } out_item_t;

endpackage

FILE: rtl/temp_filter_hysteresis_alarm.sv
// Temperature alarm with an eighth-step IIR input filter and hysteresis. Each
// transaction on the in_ channel is either a sample (op 0) or an evaluate request
// (op 1), and gives exactly one result on the out_ channel. One item is taken per
// cycle while in_stall is low: conversion, filter step and alarm decision are done
// in the accepting cycle, and the result is registered in the output or skid register.
// A two-entry output buffer (output register plus skid register) keeps in_stall
// low while one result waits; in_stall rises only when both entries are full.
// Configuration writes are always ready and should be issued only while idle.
`include "temp_filter_hysteresis_alarm_assert.svh"

module temp_filter_hysteresis_alarm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tfha_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tfha_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // configuration
  logic [1:0]         sensor_revision_r;
  logic signed [15:0] warning_thresh_r;
  logic signed [15:0] crit_high_thresh_r;
  logic signed [15:0] crit_low_thresh_r;
  logic [9:0]         hyst_margin_r;

  // block state
  logic signed [15:0] filter_value_r, filter_value_nxt;
  logic               have_sample_r, have_sample_nxt;
  tfha_pkg::alarm_t   current_alarm_r, current_alarm_nxt;
  tfha_pkg::alarm_t   shown_alarm_r, shown_alarm_nxt;

  // output buffer
  logic                out_valid_r;
  tfha_pkg::out_item_t out_item_r;
  logic                skid_valid_r;
  tfha_pkg::out_item_t skid_item_r;

  logic                in_accept;
  tfha_pkg::out_item_t result;

  logic signed [19:0] scaled;
  logic signed [15:0] cur_deci;
  logic signed [16:0] diff;
  logic signed [16:0] step;
  logic signed [17:0] filt_sum;
  logic signed [17:0] f_wide;
  logic signed [17:0] m_wide;
  tfha_pkg::alarm_t   tgt_mid, tgt_lo, tgt_hi;
  logic               changed;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic tfha_pkg::alarm_t target_of(
    input logic signed [17:0] t,
    input logic signed [15:0] warn,
    input logic signed [15:0] crit_hi,
    input logic signed [15:0] crit_lo
  );
    tfha_pkg::alarm_t a;
    if (t >= 18'(crit_hi)) begin
      a = tfha_pkg::ALARM_CRIT_HIGH;
    end else if (t >= 18'(warn)) begin
      a = tfha_pkg::ALARM_WARNING;
    end else if (t < 18'(crit_lo)) begin
      a = tfha_pkg::ALARM_CRIT_LOW;
    end else begin
      a = tfha_pkg::ALARM_NORMAL;
    end
    return a;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_revision_r  <= tfha_pkg::RESET_SENSOR_REVISION;
      warning_thresh_r   <= tfha_pkg::RESET_WARNING_THRESH;
      crit_high_thresh_r <= tfha_pkg::RESET_CRIT_HIGH_THRESH;
      crit_low_thresh_r  <= tfha_pkg::RESET_CRIT_LOW_THRESH;
      hyst_margin_r      <= tfha_pkg::RESET_HYST_MARGIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tfha_pkg::CFG_SENSOR_REVISION:   sensor_revision_r  <= cfg_data[1:0];
        tfha_pkg::CFG_WARNING_THRESHOLD: warning_thresh_r   <= cfg_data;
        tfha_pkg::CFG_CRIT_HIGH_THRESH:  crit_high_thresh_r <= cfg_data;
        tfha_pkg::CFG_CRIT_LOW_THRESH:   crit_low_thresh_r  <= cfg_data;
        tfha_pkg::CFG_HYSTERESIS_MARGIN: hyst_margin_r      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sample conversion and filter step
  always_comb begin
    scaled = $signed({{4{in_item.raw_sample[15]}}, in_item.raw_sample}) * 20'sd10;
    case (sensor_revision_r)
      tfha_pkg::REV_A_DEGREES:      cur_deci = sat16(scaled);
      tfha_pkg::REV_B_DECI_DEGREES: cur_deci = in_item.raw_sample;
      default:                      cur_deci = 16'sd0;
    endcase
    diff     = 17'(cur_deci) - 17'(filter_value_r);
    // arithmetic shift rounds toward minus infinity
    step     = diff >>> tfha_pkg::FILTER_SHIFT;
    filt_sum = 18'(filter_value_r) + 18'(step);
  end

  // alarm decision, thresholds compared at 18 bits so f +/- margin never wraps
  always_comb begin
    f_wide  = 18'(filter_value_r);
    m_wide  = $signed({8'd0, hyst_margin_r});
    tgt_mid = target_of(f_wide, warning_thresh_r, crit_high_thresh_r, crit_low_thresh_r);
    tgt_lo  = target_of(f_wide - m_wide, warning_thresh_r, crit_high_thresh_r,
                        crit_low_thresh_r);
    tgt_hi  = target_of(f_wide + m_wide, warning_thresh_r, crit_high_thresh_r,
                        crit_low_thresh_r);
  end

  always_comb begin
    filter_value_nxt  = filter_value_r;
    have_sample_nxt   = have_sample_r;
    current_alarm_nxt = current_alarm_r;
    shown_alarm_nxt   = shown_alarm_r;
    changed           = 1'b0;
    if (in_accept) begin
      if (!in_item.op) begin
        have_sample_nxt = 1'b1;
        if (have_sample_r) begin
          filter_value_nxt = sat16(20'(filt_sum));
        end else begin
          filter_value_nxt = cur_deci;
        end
      end else begin
        case (current_alarm_r)
          tfha_pkg::ALARM_UNKNOWN,
          tfha_pkg::ALARM_NORMAL:   current_alarm_nxt = tgt_mid;
          tfha_pkg::ALARM_CRIT_LOW: current_alarm_nxt = tgt_lo;
          default: begin
            // leaving warning or critical high downward needs the margin
            if (3'(tgt_mid) >= 3'(current_alarm_r)) begin
              current_alarm_nxt = tgt_mid;
            end else begin
              current_alarm_nxt = tgt_hi;
            end
          end
        endcase
        changed         = (current_alarm_nxt != shown_alarm_r);
        shown_alarm_nxt = current_alarm_nxt;
      end
    end
    result.filtered_temp = filter_value_nxt;
    result.alarm_state   = current_alarm_nxt;
    result.normal_led    = (current_alarm_nxt == tfha_pkg::ALARM_NORMAL);
    result.warning_led   = (current_alarm_nxt == tfha_pkg::ALARM_WARNING);
    result.led_red       = (current_alarm_nxt == tfha_pkg::ALARM_CRIT_LOW) ||
                           (current_alarm_nxt == tfha_pkg::ALARM_CRIT_HIGH);
    result.state_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_value_r  <= tfha_pkg::RESET_FILTER_VALUE;
      have_sample_r   <= 1'b0;
      current_alarm_r <= tfha_pkg::ALARM_UNKNOWN;
      shown_alarm_r   <= tfha_pkg::ALARM_UNKNOWN;
    end else begin
      filter_value_r  <= filter_value_nxt;
      have_sample_r   <= have_sample_nxt;
      current_alarm_r <= current_alarm_nxt;
      shown_alarm_r   <= shown_alarm_nxt;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (in_accept) begin
        out_item_r <= result;
      end
    end else if (in_accept) begin
      skid_item_r <= result;
    end
  end

  `TFHA_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_r,
                     out_valid_r && $past(out_stall))
  `TFHA_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && !out_stall,
                    !skid_valid_r && out_valid_r)
  `TFHA_ASSERT_NEXT(a_eval_syncs_shown, clk, rst_n, in_accept && in_item.op,
                    shown_alarm_r == current_alarm_r)
  `TFHA_ASSERT_IMPLY(a_change_known, clk, rst_n, out_valid_r && out_item_r.state_changed,
                     out_item_r.alarm_state != tfha_pkg::ALARM_UNKNOWN)

endmodule

FILE: verif/temp_filter_hysteresis_alarm_tb.sv
module temp_filter_hysteresis_alarm_tb;
  import tfha_pkg::*;

  localparam logic       OP_SAMPLE      = 1'b0;
  localparam logic       OP_EVALUATE    = 1'b1;
  localparam logic [1:0] REV_UNKNOWN    = 2'd2;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         RANDOM_PHASES  = 10;
  localparam int         PHASE_ITEMS    = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  temp_filter_hysteresis_alarm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // settings as the block should hold them
  logic [1:0]         rev_cfg;
  logic signed [15:0] warn_cfg;
  logic signed [15:0] crit_high_cfg;
  logic signed [15:0] crit_low_cfg;
  logic [9:0]         margin_cfg;

  // filter and alarm state as the block should hold it
  logic signed [15:0] filter_q;
  logic               have_reading;
  alarm_t             alarm_q;
  alarm_t             shown_q;

  in_item_t  queued_requests[$];
  out_item_t pending_readings[$];
  out_item_t want_reading;

  bit idle_on = 1'b1;
  int hold_req_cnt = 0;
  int hold_served = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int err_cnt = 0;
  int samples_sent = 0;
  int evals_sent = 0;
  int changes_seen = 0;
  int in_stall_cycles = 0;
  int settings_used = 0;

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 50) $display("mismatch: %s", msg);
  endtask

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int to_deci_degrees(logic signed [15:0] raw);
    case (rev_cfg)
      REV_A_DEGREES:      return sat16(int'(raw) * 10);
      REV_B_DECI_DEGREES: return int'(raw);
      default:            return 0;
    endcase
  endfunction

  function automatic alarm_t alarm_target(int t);
    if (t >= int'(crit_high_cfg)) return ALARM_CRIT_HIGH;
    if (t >= int'(warn_cfg)) return ALARM_WARNING;
    if (t < int'(crit_low_cfg)) return ALARM_CRIT_LOW;
    return ALARM_NORMAL;
  endfunction

  // margin is applied in full int width so it never wraps
  function automatic alarm_t next_alarm(alarm_t cur, int f);
    alarm_t up;
    case (cur)
      ALARM_UNKNOWN, ALARM_NORMAL: return alarm_target(f);
      ALARM_CRIT_LOW:              return alarm_target(f - int'(margin_cfg));
      default: begin
        up = alarm_target(f);
        if (up >= cur) return up;
        return alarm_target(f + int'(margin_cfg));
      end
    endcase
  endfunction

  function automatic out_item_t predict_reading(in_item_t it);
    out_item_t r;
    int        deci;
    r.state_changed = 1'b0;
    if (it.op == OP_SAMPLE) begin
      deci = to_deci_degrees(it.raw_sample);
      if (have_reading) begin
        // arithmetic shift of an int floors toward minus infinity
        filter_q = 16'(sat16(int'(filter_q) + ((deci - int'(filter_q)) >>> FILTER_SHIFT)));
      end else begin
        filter_q = 16'(deci);
        have_reading = 1'b1;
      end
    end else begin
      alarm_q = next_alarm(alarm_q, int'(filter_q));
      if (alarm_q != shown_q) begin
        shown_q = alarm_q;
        r.state_changed = 1'b1;
      end
    end
    r.filtered_temp = filter_q;
    r.alarm_state   = alarm_q;
    r.normal_led    = (alarm_q == ALARM_NORMAL);
    r.warning_led   = (alarm_q == ALARM_WARNING);
    r.led_red       = (alarm_q == ALARM_CRIT_LOW) || (alarm_q == ALARM_CRIT_HIGH);
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_idle();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rev_cfg       = RESET_SENSOR_REVISION;
      warn_cfg      = RESET_WARNING_THRESH;
      crit_high_cfg = RESET_CRIT_HIGH_THRESH;
      crit_low_cfg  = RESET_CRIT_LOW_THRESH;
      margin_cfg    = RESET_HYST_MARGIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_SENSOR_REVISION:   rev_cfg = cfg_data[1:0];
        CFG_WARNING_THRESHOLD: warn_cfg = cfg_data;
        CFG_CRIT_HIGH_THRESH:  crit_high_cfg = cfg_data;
        CFG_CRIT_LOW_THRESH:   crit_low_cfg = cfg_data;
        CFG_HYSTERESIS_MARGIN: margin_cfg = cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      filter_q = RESET_FILTER_VALUE;
      have_reading = 1'b0;
      alarm_q = ALARM_UNKNOWN;
      shown_q = ALARM_UNKNOWN;
      gap_left = 0;
    end else begin
      if (in_valid && in_stall) in_stall_cycles++;
      if (in_valid && !in_stall) begin
        pending_readings.push_back(predict_reading(in_item));
        if (in_item.op == OP_SAMPLE) samples_sent++;
        else evals_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= queued_requests.pop_front();
          gap_left = pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("result transaction with no pending reading");
        end else begin
          want_reading = pending_readings.pop_front();
          if (out_item.state_changed) changes_seen++;
          if (out_item.filtered_temp !== want_reading.filtered_temp)
            report_mismatch($sformatf("filtered_temp %0d, want %0d",
              out_item.filtered_temp, want_reading.filtered_temp));
          if (out_item.alarm_state !== want_reading.alarm_state)
            report_mismatch($sformatf("alarm_state %0d, want %0d",
              out_item.alarm_state, want_reading.alarm_state));
          if (out_item.normal_led !== want_reading.normal_led)
            report_mismatch($sformatf("normal_led %b, want %b",
              out_item.normal_led, want_reading.normal_led));
          if (out_item.warning_led !== want_reading.warning_led)
            report_mismatch($sformatf("warning_led %b, want %b",
              out_item.warning_led, want_reading.warning_led));
          if (out_item.led_red !== want_reading.led_red)
            report_mismatch($sformatf("led_red %b, want %b",
              out_item.led_red, want_reading.led_red));
          if (out_item.state_changed !== want_reading.state_changed)
            report_mismatch($sformatf("state_changed %b, want %b",
              out_item.state_changed, want_reading.state_changed));
        end
      end
      // long hold-off so the output buffer fills and the input stalls
      if (hold_served != hold_req_cnt) begin
        hold_served = hold_req_cnt;
        stall_left = $urandom_range(80, 120);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_item(logic op, logic [15:0] raw);
    in_item_t it;
    it.op = op;
    it.raw_sample = raw;
    queued_requests.push_back(it);
  endfunction

  task automatic cfg_write(cfg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || pending_readings.size() != 0);
  endtask

  // deci-degree level near a threshold, beyond the 16-bit range, or anywhere
  function automatic int pick_level();
    int r;
    int spread;
    r = $urandom_range(0, 9);
    spread = int'(margin_cfg) + 60;
    case (r)
      0, 1:    return int'(warn_cfg) + $urandom_range(0, 2 * spread) - spread;
      2, 3:    return int'(crit_high_cfg) + $urandom_range(0, 2 * spread) - spread;
      4, 5:    return int'(crit_low_cfg) + $urandom_range(0, 2 * spread) - spread;
      6, 7:    return $urandom_range(0, 1) ? 40000 : -40000;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic logic [15:0] level_to_raw(int lvl);
    case (rev_cfg)
      REV_A_DEGREES:      return 16'(sat16(lvl / 10));
      REV_B_DECI_DEGREES: return 16'(sat16(lvl));
      default:            return 16'($urandom);
    endcase
  endfunction

  // a run of samples settling toward a level, then one or two evaluations, or at times one random item
  function automatic int queue_run();
    int lvl, n, e, k;
    if ($urandom_range(0, 99) < 15) begin
      push_item(1'($urandom), 16'($urandom));
      return 1;
    end
    lvl = pick_level();
    n = $urandom_range(0, 12);
    e = $urandom_range(1, 2);
    for (k = 0; k < n; k++)
      push_item(OP_SAMPLE, level_to_raw(lvl + $urandom_range(0, 8) - 4));
    for (k = 0; k < e; k++)
      push_item(OP_EVALUATE, 16'($urandom));
    return n + e;
  endfunction

  task automatic rand_config();
    int r, lo, w, hi;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      lo = $urandom_range(0, 1000) - 500;
      w  = lo + $urandom_range(100, 1500);
      hi = w + $urandom_range(0, 1000);
    end else if (r < 8) begin
      lo = $urandom_range(0, 1) ? 32767 : -32768;
      w  = $urandom_range(0, 1) ? 32767 : -32768;
      hi = $urandom_range(0, 1) ? 32767 : -32768;
    end else begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      w  = int'($urandom_range(0, 65535)) - 32768;
      hi = int'($urandom_range(0, 65535)) - 32768;
    end
    cfg_write(CFG_SENSOR_REVISION, 16'($urandom_range(0, 2)));
    cfg_write(CFG_WARNING_THRESHOLD, 16'(w));
    cfg_write(CFG_CRIT_HIGH_THRESH, 16'(hi));
    cfg_write(CFG_CRIT_LOW_THRESH, 16'(lo));
    r = $urandom_range(0, 3);
    cfg_write(CFG_HYSTERESIS_MARGIN,
              (r == 0) ? 16'd0 : (r == 1) ? 16'd1023 : 16'($urandom_range(0, 200)));
    settings_used++;
  endtask

  initial begin
    int p, added;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // evaluate before any sample: runs on the reset filter value
    @(negedge clk);
    push_item(OP_EVALUATE, 16'h0000);
    push_item(OP_EVALUATE, 16'hffff);
    wait_drained();

    // first sample loads the filter; margin added near the top must not wrap
    cfg_write(CFG_SENSOR_REVISION, 16'(REV_B_DECI_DEGREES));
    cfg_write(CFG_HYSTERESIS_MARGIN, 16'd1023);
    cfg_write(CFG_WARNING_THRESHOLD, 16'd0);
    cfg_write(CFG_CRIT_HIGH_THRESH, 16'd32000);
    cfg_write(CFG_CRIT_LOW_THRESH, 16'(-32000));
    settings_used += 2;
    @(negedge clk);
    push_item(OP_SAMPLE, 16'h7fff);
    push_item(OP_EVALUATE, 16'h0000);
    push_item(OP_SAMPLE, 16'd30000);
    push_item(OP_SAMPLE, 16'd30000);
    push_item(OP_SAMPLE, 16'd30000);
    push_item(OP_EVALUATE, 16'h0000);
    push_item(OP_SAMPLE, 16'h8000);
    push_item(OP_EVALUATE, 16'h0000);
    wait_drained();

    // unknown revision converts to zero; thresholds out of order
    cfg_write(CFG_SENSOR_REVISION, 16'(REV_UNKNOWN));
    cfg_write(CFG_WARNING_THRESHOLD, 16'd1000);
    cfg_write(CFG_CRIT_HIGH_THRESH, 16'd500);
    cfg_write(CFG_CRIT_LOW_THRESH, 16'd30000);
    cfg_write(CFG_HYSTERESIS_MARGIN, 16'd0);
    settings_used++;
    @(negedge clk);
    push_item(OP_SAMPLE, 16'h5555);
    push_item(OP_SAMPLE, 16'haaaa);
    push_item(OP_EVALUATE, 16'h0000);
    push_item(OP_SAMPLE, 16'h7fff);
    push_item(OP_EVALUATE, 16'h0000);
    wait_drained();

    // degree readings that saturate both ways, thresholds at the extremes
    cfg_write(CFG_SENSOR_REVISION, 16'(REV_A_DEGREES));
    cfg_write(CFG_WARNING_THRESHOLD, 16'h7fff);
    cfg_write(CFG_CRIT_HIGH_THRESH, 16'h7fff);
    cfg_write(CFG_CRIT_LOW_THRESH, 16'h8000);
    settings_used++;
    @(negedge clk);
    push_item(OP_SAMPLE, 16'h8000);
    push_item(OP_SAMPLE, 16'(-3277));
    push_item(OP_EVALUATE, 16'h0000);
    push_item(OP_SAMPLE, 16'd3277);
    push_item(OP_EVALUATE, 16'h0000);
    wait_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      rand_config();
      @(negedge clk);
      idle_on = (p != 5);
      if (p == 3 || p == 7) begin
        idle_on = 1'b0;
        hold_req_cnt++;
      end
      added = 0;
      while (added < PHASE_ITEMS) added += queue_run();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (pending_readings.size() != 0)
      report_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
    $display("ran %0d samples and %0d evaluations under %0d register settings",
             samples_sent, evals_sent, settings_used);
    $display("%0d alarm changes seen, input stalled %0d cycles, %0d mismatches",
             changes_seen, in_stall_cycles, err_cnt);
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
